FILE: src/dhcprlp_pkg.sv
// ----------------------------------------------------------------------------
// DHCP reply lease parser package
// Word types, header offsets, option codes and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dhcprlp_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 2048;

    localparam int XID_START     = 4;
    localparam int XID_END       = 8;
    localparam int YIADDR_START  = 16;
    localparam int YIADDR_END    = 20;
    localparam int FIXED_LEN     = 236;
    localparam int OPTS_START    = 240;

    localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
    localparam logic [7:0]  OP_BOOTREPLY = 8'd2;
    localparam logic [7:0]  TYPE_OFFER   = 8'd2;
    localparam logic [7:0]  TYPE_ACK     = 8'd5;

    localparam logic [7:0] CODE_PAD    = 8'd0;
    localparam logic [7:0] CODE_MASK   = 8'd1;
    localparam logic [7:0] CODE_ROUTER = 8'd3;
    localparam logic [7:0] CODE_DNS    = 8'd6;
    localparam logic [7:0] CODE_TYPE   = 8'd53;
    localparam logic [7:0] CODE_END    = 8'd255;

    localparam int OPT_TYPE   = 0;
    localparam int OPT_MASK   = 1;
    localparam int OPT_ROUTER = 2;
    localparam int OPT_DNS    = 3;
    localparam int OPT_NUM    = 4;

    localparam logic [2:0] ADDR_BYTES = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_NOT_REPLY = 3'd4;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd5;
    localparam logic [2:0] ST_NO_TYPE   = 3'd6;

    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN,
        PH_VALUE,
        PH_DONE
    } t_walk_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] transaction_id;
        logic [31:0] offered_addr;
        logic [7:0]  message_type;
        logic        prefix_ok;
        logic [5:0]  prefix_length;
        logic        gateway_ok;
        logic [31:0] gateway_addr;
        logic        has_dns;
        logic [31:0] dns_addr;
    } t_out_word;

    typedef struct packed {
        logic        type_ok;
        logic [7:0]  type_value;
        logic        mask_ok;
        logic [5:0]  prefix;
        logic        router_ok;
        logic [31:0] router;
        logic        dns_ok;
        logic [31:0] dns;
    } t_opt_info;

    function automatic logic [OPT_NUM-1:0] code_bit(input logic [7:0] code);
        logic [OPT_NUM-1:0] bits;
        bits = '0;
        case (code)
            CODE_TYPE:   bits[OPT_TYPE]   = 1'b1;
            CODE_MASK:   bits[OPT_MASK]   = 1'b1;
            CODE_ROUTER: bits[OPT_ROUTER] = 1'b1;
            CODE_DNS:    bits[OPT_DNS]    = 1'b1;
            default:     bits = '0;
        endcase
        return bits;
    endfunction

endpackage

FILE: src/dhcprlp_opt_walker.sv
// ----------------------------------------------------------------------------
// DHCP option walker
// Walks the option list one byte at a time and keeps the first occurrence of
// message type, subnet mask, router and DNS. Shows the post-update view.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhcprlp_opt_walker
    import dhcprlp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    output t_opt_info  o_info
);

    t_walk_phase        r_phase, n_phase;
    logic [7:0]         r_code, n_code;
    logic [7:0]         r_remain, n_remain;
    logic [31:0]        r_value, n_value;
    logic [2:0]         r_count, n_count;
    logic [OPT_NUM-1:0] r_decided, n_decided;
    logic [OPT_NUM-1:0] r_valid, n_valid;
    logic [31:0]        r_mask, n_mask;
    logic [31:0]        r_router, n_router;
    logic [31:0]        r_dns, n_dns;
    logic [7:0]         r_type, n_type;

    logic [7:0]         remain_dec;
    logic               finish;
    logic [OPT_NUM-1:0] cur_bit;

    function automatic logic [5:0] leading_ones(input logic [31:0] m);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (!m[i]) begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

    assign remain_dec = r_remain - 8'd1;
    assign cur_bit    = code_bit(r_code);

    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            case (r_phase)
                PH_CODE: begin
                    if (i_byte == CODE_END) begin
                        n_phase = PH_DONE;
                    end else if (i_byte != CODE_PAD) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_phase = (i_byte == 8'd0) ? PH_CODE : PH_VALUE;
                end
                PH_VALUE: begin
                    if (remain_dec == 8'd0) begin
                        n_phase = PH_CODE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_CODE;
                end
            endcase
        end
    end

    always_comb begin
        n_code    = r_code;
        n_remain  = r_remain;
        n_value   = r_value;
        n_count   = r_count;
        n_decided = r_decided;
        n_valid   = r_valid;
        n_mask    = r_mask;
        n_router  = r_router;
        n_dns     = r_dns;
        n_type    = r_type;
        finish    = 1'b0;
        if (i_step) begin
            case (r_phase)
                PH_CODE: begin
                    if (i_byte != CODE_END && i_byte != CODE_PAD) begin
                        n_code = i_byte;
                    end
                end
                PH_LEN: begin
                    n_remain = i_byte;
                    n_value  = '0;
                    n_count  = '0;
                    finish   = (i_byte == 8'd0);
                end
                PH_VALUE: begin
                    if (r_count < ADDR_BYTES) begin
                        n_value = {r_value[23:0], i_byte};
                        n_count = r_count + 3'd1;
                    end
                    n_remain = remain_dec;
                    finish   = (remain_dec == 8'd0);
                end
                PH_DONE: begin
                    finish = 1'b0;
                end
                default: begin
                    finish = 1'b0;
                end
            endcase
        end
        if (finish && (cur_bit != '0) && ((r_decided & cur_bit) == '0)) begin
            n_decided = r_decided | cur_bit;
            if (cur_bit[OPT_TYPE]) begin
                if (n_count != 3'd0 && n_count <= ADDR_BYTES) begin
                    n_valid = n_valid | cur_bit;
                    case (n_count)
                        3'd1:    n_type = n_value[7:0];
                        3'd2:    n_type = n_value[15:8];
                        3'd3:    n_type = n_value[23:16];
                        default: n_type = n_value[31:24];
                    endcase
                end
            end else if (n_count == ADDR_BYTES) begin
                n_valid = n_valid | cur_bit;
                if (cur_bit[OPT_MASK]) begin
                    n_mask = n_value;
                end else if (cur_bit[OPT_ROUTER]) begin
                    n_router = n_value;
                end else begin
                    n_dns = n_value;
                end
            end
        end
    end

    always_comb begin
        o_info.type_ok    = n_valid[OPT_TYPE];
        o_info.type_value = n_type;
        o_info.mask_ok    = n_valid[OPT_MASK];
        o_info.prefix     = leading_ones(n_mask);
        o_info.router_ok  = n_valid[OPT_ROUTER];
        o_info.router     = n_router;
        o_info.dns_ok     = n_valid[OPT_DNS];
        o_info.dns        = n_dns;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase   <= PH_CODE;
            r_code    <= '0;
            r_remain  <= '0;
            r_value   <= '0;
            r_count   <= '0;
            r_decided <= '0;
            r_valid   <= '0;
            r_mask    <= '0;
            r_router  <= '0;
            r_dns     <= '0;
            r_type    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_code    <= n_code;
            r_remain  <= n_remain;
            r_value   <= n_value;
            r_count   <= n_count;
            r_decided <= n_decided;
            r_valid   <= n_valid;
            r_mask    <= n_mask;
            r_router  <= n_router;
            r_dns     <= n_dns;
            r_type    <= n_type;
        end
    end

`ifndef SYNTHESIS
    a_valid_in_decided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid & ~r_decided) == '0)
        else $error("option valid without option decided");

    a_value_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_VALUE |-> r_remain != 8'd0)
        else $error("value phase with nothing left");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ADDR_BYTES)
        else $error("captured count past four");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> r_decided == '0 && r_phase == PH_CODE)
        else $error("walker not cleared after last byte");
`endif

endmodule

FILE: src/dhcp_reply_lease_parser_top.sv
// ----------------------------------------------------------------------------
// DHCP reply lease parser
// Parses a DHCP reply byte stream and reports lease status and fields.
// ----------------------------------------------------------------------------
// Input channel: one payload byte per word (i_in_word.data_byte), with
// last_byte set on the final byte of the UDP payload. Output channel: one
// result word per packet, given after the byte marked last.
// Throughput: one byte per cycle while no final byte waits on a stalled result.
// The byte goes into an input register, and the header capture, option walk
// and status decision run combinationally from it into the result register.
// A new packet may follow the last byte at once; all packet state clears as
// the last byte is processed.
// When the receiver stalls, the result holds; non-final bytes keep flowing,
// and only a final byte waits in the input register until the result is taken.
// Reset clears all packet state and both valid flags; nothing is lost or
// produced across it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhcp_reply_lease_parser_top
    import dhcprlp_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 2);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET_BYTES);

    logic             r_in_valid;
    t_in_word         r_in;
    logic             r_out_valid;
    t_out_word        r_out, n_out;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_op_reply, n_op_reply;
    logic [31:0]      r_xid, n_xid;
    logic [31:0]      r_yiaddr, n_yiaddr;
    logic [31:0]      r_cookie, n_cookie;

    logic             proc;
    logic             in_range;
    logic             walk_step;
    logic             pkt_end;
    t_opt_info        opt_info;

    assign proc       = r_in_valid && !(r_in.last_byte && r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !proc;
    assign pkt_end    = proc && r_in.last_byte;
    assign in_range   = r_pos < MAX_POS;
    assign walk_step  = proc && in_range && (r_pos >= POS_W'(OPTS_START));

    always_comb begin
        n_op_reply = r_op_reply;
        n_xid      = r_xid;
        n_yiaddr   = r_yiaddr;
        n_cookie   = r_cookie;
        n_pos      = r_pos;
        if (proc) begin
            if (in_range) begin
                if (r_pos == '0) begin
                    n_op_reply = (r_in.data_byte == OP_BOOTREPLY);
                end
                if (r_pos >= POS_W'(XID_START) && r_pos < POS_W'(XID_END)) begin
                    n_xid = {r_xid[23:0], r_in.data_byte};
                end
                if (r_pos >= POS_W'(YIADDR_START) && r_pos < POS_W'(YIADDR_END)) begin
                    n_yiaddr = {r_yiaddr[23:0], r_in.data_byte};
                end
                if (r_pos >= POS_W'(FIXED_LEN) && r_pos < POS_W'(OPTS_START)) begin
                    n_cookie = {r_cookie[23:0], r_in.data_byte};
                end
            end
            if (r_pos <= MAX_POS) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    dhcprlp_opt_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (walk_step),
        .i_clear (pkt_end),
        .i_byte  (r_in.data_byte),
        .o_info  (opt_info)
    );

    always_comb begin
        n_out = '0;
        if (n_pos > MAX_POS) begin
            n_out.status = ST_TOO_LONG;
        end else if (n_pos < POS_W'(OPTS_START)) begin
            n_out.status = ST_SHORT;
        end else if (!n_op_reply) begin
            n_out.status = ST_NOT_REPLY;
        end else if (n_cookie != MAGIC_COOKIE) begin
            n_out.status = ST_BAD_MAGIC;
        end else if (!opt_info.type_ok) begin
            n_out.status = ST_NO_TYPE;
        end else if (opt_info.type_value != TYPE_OFFER && opt_info.type_value != TYPE_ACK) begin
            n_out.status = ST_BAD_TYPE;
        end else begin
            n_out.status = ST_OK;
        end
        if (n_out.status == ST_OK || n_out.status == ST_BAD_TYPE
                || n_out.status == ST_BAD_MAGIC || n_out.status == ST_NO_TYPE) begin
            n_out.transaction_id = n_xid;
            n_out.offered_addr   = n_yiaddr;
        end
        if (n_out.status == ST_OK || n_out.status == ST_BAD_TYPE) begin
            n_out.message_type = opt_info.type_value;
        end
        if (n_out.status == ST_OK) begin
            if (opt_info.mask_ok) begin
                n_out.prefix_ok     = 1'b1;
                n_out.prefix_length = opt_info.prefix;
            end
            if (opt_info.router_ok) begin
                n_out.gateway_ok   = 1'b1;
                n_out.gateway_addr = opt_info.router;
            end
            if (opt_info.dns_ok) begin
                n_out.has_dns  = 1'b1;
                n_out.dns_addr = opt_info.dns;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || pkt_end) begin
            r_pos      <= '0;
            r_op_reply <= 1'b0;
            r_xid      <= '0;
            r_yiaddr   <= '0;
            r_cookie   <= '0;
        end else begin
            r_pos      <= n_pos;
            r_op_reply <= n_op_reply;
            r_xid      <= n_xid;
            r_yiaddr   <= n_yiaddr;
            r_cookie   <= n_cookie;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pkt_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pkt_end) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_in.last_byte && r_out_valid && i_out_stall)
        else $error("input stalled without a waiting result");

    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pkt_end |=> r_pos == '0)
        else $error("byte count not cleared after last byte");

    a_fail_no_opts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_OK
            |-> !r_out.prefix_ok && !r_out.gateway_ok && !r_out.has_dns)
        else $error("option fields on a failed lease");

    a_early_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status == ST_SHORT || r_out.status == ST_TOO_LONG
            || r_out.status == ST_NOT_REPLY)
            |-> r_out.transaction_id == '0 && r_out.offered_addr == '0)
        else $error("header fields on an early failure");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= MAX_POS + POS_W'(1))
        else $error("byte count past saturation");
`endif

endmodule

FILE: dv/dhcp_reply_lease_parser_top_tb.sv
// ----------------------------------------------------------------------------
// DHCP reply lease parser testbench
// Streams whole DHCP replies into the parser one byte per word. A scoreboard
// tracks header capture, cookie check and the option walk for every accepted
// byte. It compares each result word, field by field, with the lease it
// predicts. Directed replies cover length limits, bad headers, short,
// repeated and truncated options, and bytes after the end option. Random
// replies follow, mostly well formed. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhcp_reply_lease_parser_top_tb
    import dhcprlp_pkg::*;
;

    localparam int          MAX_BYTES   = MAX_PACKET_BYTES_DEF;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          RANDOM_REPLIES = 48;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;
    logic      i_out_stall = 1'b0;

    bit          quiet_stretch = 1'b0;
    int unsigned cycle_count   = 0;
    logic [7:0]  reply_bytes[$];

    class lease_scoreboard;
        int unsigned      byte_count;
        bit               op_reply;
        bit [31:0]        xid_acc;
        bit [31:0]        yiaddr_acc;
        bit [31:0]        cookie_acc;
        t_walk_phase      phase;
        bit [7:0]         opt_code;
        bit [7:0]         opt_left;
        bit [31:0]        value_acc;
        int unsigned      opt_taken;
        bit [OPT_NUM-1:0] decided;
        bit [OPT_NUM-1:0] found;
        bit [31:0]        mask_word;
        bit [31:0]        router_word;
        bit [31:0]        dns_word;
        bit [7:0]         type_byte;
        t_out_word        expected_leases[$];
        int unsigned      failures;

        function void clear_packet();
            byte_count  = 0;
            op_reply    = 1'b0;
            xid_acc     = '0;
            yiaddr_acc  = '0;
            cookie_acc  = '0;
            phase       = PH_CODE;
            opt_code    = '0;
            opt_left    = '0;
            value_acc   = '0;
            opt_taken   = 0;
            decided     = '0;
            found       = '0;
            mask_word   = '0;
            router_word = '0;
            dns_word    = '0;
            type_byte   = '0;
        endfunction

        function void close_option();
            int slot;
            slot = -1;
            case (opt_code)
                CODE_TYPE:   slot = OPT_TYPE;
                CODE_MASK:   slot = OPT_MASK;
                CODE_ROUTER: slot = OPT_ROUTER;
                CODE_DNS:    slot = OPT_DNS;
                default:     slot = -1;
            endcase
            phase = PH_CODE;
            if (slot < 0) return;
            if (decided[slot]) return;
            decided[slot] = 1'b1;
            if (slot == OPT_TYPE) begin
                if (opt_taken >= 1) begin
                    type_byte   = 8'(value_acc >> (8 * (opt_taken - 1)));
                    found[slot] = 1'b1;
                end
                return;
            end
            if (opt_taken == 4) begin
                found[slot] = 1'b1;
                case (slot)
                    OPT_MASK:   mask_word   = value_acc;
                    OPT_ROUTER: router_word = value_acc;
                    default:    dns_word    = value_acc;
                endcase
            end
        endfunction

        function void parse_byte(bit [7:0] b, bit last);
            t_out_word   lease;
            int unsigned ones;
            if (byte_count < MAX_BYTES) begin
                if (byte_count == 0) op_reply = (b == OP_BOOTREPLY);
                if (byte_count >= XID_START && byte_count < XID_END)
                    xid_acc = {xid_acc[23:0], b};
                if (byte_count >= YIADDR_START && byte_count < YIADDR_END)
                    yiaddr_acc = {yiaddr_acc[23:0], b};
                if (byte_count >= FIXED_LEN && byte_count < OPTS_START)
                    cookie_acc = {cookie_acc[23:0], b};
                if (byte_count >= OPTS_START) begin
                    case (phase)
                        PH_CODE: begin
                            if (b == CODE_END) begin
                                phase = PH_DONE;
                            end else if (b != CODE_PAD) begin
                                opt_code = b;
                                phase    = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            opt_left  = b;
                            value_acc = '0;
                            opt_taken = 0;
                            if (b == 8'd0) close_option();
                            else phase = PH_VALUE;
                        end
                        PH_VALUE: begin
                            if (opt_taken < 4) begin
                                value_acc = {value_acc[23:0], b};
                                opt_taken++;
                            end
                            opt_left--;
                            if (opt_left == 8'd0) close_option();
                        end
                        default: ;
                    endcase
                end
            end
            if (byte_count <= MAX_BYTES) byte_count++;
            if (!last) return;

            lease = '0;
            if (byte_count > MAX_BYTES)                         lease.status = ST_TOO_LONG;
            else if (byte_count < OPTS_START)                   lease.status = ST_SHORT;
            else if (!op_reply)                                 lease.status = ST_NOT_REPLY;
            else if (cookie_acc != MAGIC_COOKIE)                lease.status = ST_BAD_MAGIC;
            else if (!found[OPT_TYPE])                          lease.status = ST_NO_TYPE;
            else if (type_byte != TYPE_OFFER && type_byte != TYPE_ACK)
                lease.status = ST_BAD_TYPE;
            else
                lease.status = ST_OK;

            if (lease.status == ST_OK || lease.status == ST_BAD_TYPE ||
                lease.status == ST_BAD_MAGIC || lease.status == ST_NO_TYPE) begin
                lease.transaction_id = xid_acc;
                lease.offered_addr   = yiaddr_acc;
            end
            if (lease.status == ST_OK || lease.status == ST_BAD_TYPE)
                lease.message_type = type_byte;
            if (lease.status == ST_OK) begin
                if (found[OPT_MASK]) begin
                    ones = 0;
                    while (ones < 32 && mask_word[31 - ones]) ones++;
                    lease.prefix_ok     = 1'b1;
                    lease.prefix_length = ones[5:0];
                end
                if (found[OPT_ROUTER]) begin
                    lease.gateway_ok   = 1'b1;
                    lease.gateway_addr = router_word;
                end
                if (found[OPT_DNS]) begin
                    lease.has_dns  = 1'b1;
                    lease.dns_addr = dns_word;
                end
            end
            expected_leases.push_back(lease);
            clear_packet();
        endfunction

        function void check_lease(t_out_word got);
            t_out_word want;
            bit        bad;
            if (expected_leases.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected lease word: status %0d xid %h", got.status,
                             got.transaction_id);
                return;
            end
            want = expected_leases.pop_front();
            bad = got.status !== want.status || got.transaction_id !== want.transaction_id
                || got.offered_addr !== want.offered_addr
                || got.message_type !== want.message_type
                || got.prefix_ok !== want.prefix_ok
                || got.prefix_length !== want.prefix_length
                || got.gateway_ok !== want.gateway_ok
                || got.gateway_addr !== want.gateway_addr
                || got.has_dns !== want.has_dns || got.dns_addr !== want.dns_addr;
            if (!bad) return;
            failures++;
            if (failures <= 10) begin
                $display("lease mismatch (exp/got): status %0d/%0d xid %h/%h",
                         want.status, got.status, want.transaction_id, got.transaction_id);
                $display("  yiaddr %h/%h type %h/%h", want.offered_addr, got.offered_addr,
                         want.message_type, got.message_type);
                $display("  prefix %b %0d/%b %0d gw %b %h/%b %h dns %b %h/%b %h",
                         want.prefix_ok, want.prefix_length, got.prefix_ok,
                         got.prefix_length, want.gateway_ok, want.gateway_addr,
                         got.gateway_ok, got.gateway_addr, want.has_dns, want.dns_addr,
                         got.has_dns, got.dns_addr);
            end
        endfunction

        function int unsigned pending();
            return expected_leases.size();
        endfunction
    endclass

    lease_scoreboard lease_check;

    dhcp_reply_lease_parser_top #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit dice_idle();
        return !quiet_stretch && ($urandom_range(99) < 26);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("dhcp_reply_lease_parser_top_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) lease_check.check_lease(o_out_word);
        i_out_stall <= dice_idle();
    end

    function automatic void put_byte(logic [7:0] b);
        reply_bytes.push_back(b);
    endfunction

    function automatic void start_packet(logic [7:0] op, logic [31:0] xid,
                                         logic [31:0] yiaddr, logic [31:0] cookie);
        reply_bytes.delete();
        for (int i = 0; i < FIXED_LEN; i++) begin
            if (i == 0)
                put_byte(op);
            else if (i >= XID_START && i < XID_END)
                put_byte(xid[31 - 8 * (i - XID_START) -: 8]);
            else if (i >= YIADDR_START && i < YIADDR_END)
                put_byte(yiaddr[31 - 8 * (i - YIADDR_START) -: 8]);
            else
                put_byte(8'($urandom_range(255)));
        end
        for (int i = 0; i < 4; i++) put_byte(cookie[31 - 8 * i -: 8]);
    endfunction

    function automatic void put_option(logic [7:0] code, int len, logic [31:0] lead);
        put_byte(code);
        put_byte(len[7:0]);
        for (int i = 0; i < len; i++)
            put_byte(i < 4 ? lead[31 - 8 * i -: 8] : 8'($urandom_range(255)));
    endfunction

    function automatic void pad_to(int n);
        while (reply_bytes.size() < n) put_byte(8'($urandom_range(255)));
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        while (dice_idle()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= '{data_byte: b, last_byte: last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        lease_check.parse_byte(b, last);
    endtask

    task automatic send_packet();
        for (int i = 0; i < reply_bytes.size(); i++)
            send_byte(reply_bytes[i], i == reply_bytes.size() - 1);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (lease_check.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_addr_lead(logic [7:0] code);
        int p;
        if (code != CODE_MASK || $urandom_range(99) < 20) return $urandom;
        p = $urandom_range(32);
        return 32'hffff_ffff << (32 - p);
    endfunction

    function automatic int pick_addr_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 4;
        if (r < 85) return $urandom_range(12, 5);
        return $urandom_range(3);
    endfunction

    task automatic random_packet();
        int          kind;
        int          opts;
        int          r;
        int          len;
        logic [7:0]  code;
        logic [7:0]  op;
        logic [31:0] cookie;
        kind = $urandom_range(99);
        if (kind < 6) begin
            reply_bytes.delete();
            pad_to($urandom_range(OPTS_START - 1, 1));
            send_packet();
            return;
        end
        op     = ($urandom_range(99) < 92) ? OP_BOOTREPLY : 8'($urandom_range(255));
        cookie = ($urandom_range(99) < 92) ? MAGIC_COOKIE
                                           : MAGIC_COOKIE ^ (32'd1 << $urandom_range(31));
        start_packet(op, $urandom, $urandom, cookie);
        opts = $urandom_range(7);
        for (int k = 0; k < opts; k++) begin
            r = $urandom_range(99);
            if (r < 25) begin
                len = ($urandom_range(99) < 80) ? 1 : $urandom_range(6);
                code = ($urandom_range(99) < 60)
                     ? (($urandom_range(1) != 0) ? TYPE_OFFER : TYPE_ACK)
                     : 8'($urandom_range(255));
                put_option(CODE_TYPE, len, {code, 24'($urandom)});
            end else if (r < 75) begin
                code = (r < 45) ? CODE_MASK : (r < 60) ? CODE_ROUTER : CODE_DNS;
                put_option(code, pick_addr_len(), pick_addr_lead(code));
            end else if (r < 85) begin
                repeat ($urandom_range(3, 1)) put_byte(CODE_PAD);
            end else begin
                len = ($urandom_range(99) < 5) ? 255 : $urandom_range(40);
                put_option(8'($urandom_range(254, 1)), len, $urandom);
            end
        end
        r = $urandom_range(99);
        if (r < 75) begin
            put_byte(CODE_END);
            repeat ($urandom_range(5)) put_byte(8'($urandom_range(255)));
        end else if (r >= 85) begin
            len = $urandom_range(8, 2);
            code = ($urandom_range(1) != 0) ? CODE_DNS : 8'($urandom_range(254, 1));
            put_option(code, len, $urandom);
            repeat ($urandom_range(len + 1, 1)) void'(reply_bytes.pop_back());
        end
        send_packet();
    endtask

    initial begin
        lease_check = new();
        lease_check.clear_packet();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // too short: one byte, then one byte short of the cookie
        reply_bytes.delete();
        put_byte(OP_BOOTREPLY);
        send_packet();
        start_packet(OP_BOOTREPLY, 32'hffff_ffff, 32'h0000_0000, MAGIC_COOKIE);
        void'(reply_bytes.pop_back());
        send_packet();

        // header and cookie only: no type
        start_packet(OP_BOOTREPLY, 32'h0000_0000, 32'hffff_ffff, MAGIC_COOKIE);
        send_packet();

        start_packet(OP_BOOTREPLY, 32'h1234_5678, 32'hc0a8_0164, MAGIC_COOKIE);
        put_option(CODE_TYPE, 1, {TYPE_OFFER, 24'h0});
        put_option(CODE_MASK, 4, 32'hffff_ff00);
        put_option(CODE_ROUTER, 4, 32'hc0a8_0101);
        put_option(CODE_DNS, 4, 32'h0808_0808);
        put_byte(CODE_END);
        send_packet();

        // pads, full mask, repeated codes, junk after end
        start_packet(OP_BOOTREPLY, 32'h8000_0001, 32'h7fff_fffe, MAGIC_COOKIE);
        repeat (3) put_byte(CODE_PAD);
        put_option(CODE_MASK, 4, 32'hffff_ffff);
        put_option(CODE_TYPE, 1, {TYPE_ACK, 24'h0});
        put_option(CODE_TYPE, 1, {8'd3, 24'h0});
        put_option(CODE_MASK, 4, 32'h0000_0000);
        put_option(CODE_DNS, 8, 32'hffff_ffff);
        put_byte(CODE_END);
        put_option(CODE_ROUTER, 4, 32'h0a00_0001);
        send_packet();

        // zero mask, short options decide their code as absent
        start_packet(OP_BOOTREPLY, $urandom, $urandom, MAGIC_COOKIE);
        put_option(CODE_MASK, 4, 32'h0000_0000);
        put_option(CODE_ROUTER, 2, 32'haabb_ccdd);
        put_option(CODE_ROUTER, 4, 32'h0102_0304);
        put_option(CODE_DNS, 3, 32'h0102_0304);
        put_option(CODE_DNS, 4, 32'h0506_0708);
        put_option(CODE_TYPE, 4, {TYPE_ACK, 24'hff_ffff});
        put_byte(CODE_END);
        send_packet();

        // zero-length type hides a later one
        start_packet(OP_BOOTREPLY, $urandom, $urandom, MAGIC_COOKIE);
        put_option(CODE_TYPE, 0, 32'h0);
        put_option(CODE_TYPE, 1, {TYPE_ACK, 24'h0});
        put_byte(CODE_END);
        send_packet();

        start_packet(OP_BOOTREPLY, $urandom, $urandom, MAGIC_COOKIE);
        put_option(CODE_TYPE, 1, {8'd3, 24'h0});
        put_option(CODE_ROUTER, 4, 32'h0a00_0001);
        send_packet();

        start_packet(8'h01, $urandom, $urandom, MAGIC_COOKIE);
        put_option(CODE_TYPE, 1, {TYPE_ACK, 24'h0});
        send_packet();

        start_packet(OP_BOOTREPLY, $urandom, $urandom, MAGIC_COOKIE ^ 32'd1);
        put_option(CODE_TYPE, 1, {TYPE_OFFER, 24'h0});
        send_packet();

        // truncated in the value, then at the length byte
        start_packet(OP_BOOTREPLY, $urandom, $urandom, MAGIC_COOKIE);
        put_option(CODE_TYPE, 1, {TYPE_ACK, 24'h0});
        put_option(CODE_ROUTER, 4, 32'hc0a8_00fe);
        put_option(CODE_DNS, 4, 32'h0101_0101);
        repeat (2) void'(reply_bytes.pop_back());
        send_packet();
        start_packet(OP_BOOTREPLY, $urandom, $urandom, MAGIC_COOKIE);
        put_option(CODE_TYPE, 1, {TYPE_OFFER, 24'h0});
        put_byte(CODE_DNS);
        send_packet();

        // exactly the maximum, then past it
        start_packet(OP_BOOTREPLY, $urandom, $urandom, MAGIC_COOKIE);
        put_option(CODE_TYPE, 1, {TYPE_ACK, 24'h0});
        put_byte(CODE_END);
        pad_to(MAX_BYTES);
        send_packet();
        start_packet(OP_BOOTREPLY, $urandom, $urandom, MAGIC_COOKIE);
        put_option(CODE_TYPE, 1, {TYPE_ACK, 24'h0});
        put_byte(CODE_END);
        pad_to(MAX_BYTES + 52);
        send_packet();

        wait_drained();

        for (int n = 0; n < RANDOM_REPLIES; n++) begin
            quiet_stretch = (n >= 12 && n < 20);
            if (n % 10 == 9) wait_drained();
            random_packet();
        end
        quiet_stretch = 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (lease_check.failures == 0 && lease_check.pending() == 0)
            $display("dhcp_reply_lease_parser_top_tb passed");
        else
            $display("dhcp_reply_lease_parser_top_tb failed");
        $finish;
    end

endmodule
